[design/rpms_pkg.sv]
// shared types, codes and constants of the robot pose, motion and range unit
package rpms_pkg;

    // command codes of an input beat
    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_SENSE = 2'd2;
    localparam logic [1:0] CMD_LOAD  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FWD_DEV   = 2'd0;
    localparam logic [1:0] CFG_TURN_DEV  = 2'd1;
    localparam logic [1:0] CFG_SENSE_DEV = 2'd2;

    // multiplier operand pairs
    localparam logic [3:0] MUL_N1_TURN  = 4'd0;
    localparam logic [3:0] MUL_N1_SENSE = 4'd1;
    localparam logic [3:0] MUL_N2_FWD   = 4'd2;
    localparam logic [3:0] MUL_DLO_C    = 4'd3;
    localparam logic [3:0] MUL_DHI_C    = 4'd4;
    localparam logic [3:0] MUL_DLO_S    = 4'd5;
    localparam logic [3:0] MUL_DHI_S    = 4'd6;
    localparam logic [3:0] MUL_XL_XL    = 4'd7;
    localparam logic [3:0] MUL_XH_XL    = 4'd8;
    localparam logic [3:0] MUL_XH_XH    = 4'd9;
    localparam logic [3:0] MUL_YL_YL    = 4'd10;
    localparam logic [3:0] MUL_YH_YL    = 4'd11;
    localparam logic [3:0] MUL_YH_YH    = 4'd12;

    // accumulator operations and product alignments
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_17 = 2'd1;
    localparam logic [1:0] SH_18 = 2'd2;
    localparam logic [1:0] SH_34 = 2'd3;

    // cordic start vector 0.6072529350 in q4.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // square root of a 66-bit value, one result bit per step
    localparam int SQRT_STEPS = 33;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       set_pose;
        logic       lm_write;
        logic       lm_read;
        logic [3:0] mul_sel;
        logic [1:0] acc_op;
        logic [1:0] acc_sh;
        logic       nz1_cap;
        logic       nz2_cap;
        logic       head_upd;
        logic       cordic_init;
        logic       cordic_step;
        logic       cordic_fin;
        logic [4:0] iter;
        logic       pos_x_upd;
        logic       pos_y_upd;
        logic       abs_calc;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       range_upd;
        logic       out_load;
    } rpms_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       idx_ok;
        logic       out_full;
    } rpms_stat_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] rpms_atan(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680862;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] rpms_sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = $signed(v[31:0]);
        return r;
    endfunction

endpackage

[design/robot_pose_motion_and_range_sense_unit.sv]
// top level of the robot pose, motion and range unit
//
// usage:
//   in channel (in_valid/in_ready) takes one command beat: move, set pose,
//   sense landmark or load landmark. out channel (out_valid/out_ready)
//   returns one beat per command: the pose after it and, for a sense, the
//   range. cfg channel (cfg_valid/cfg_ready, always ready) writes the
//   three noise deviations; write them only while the unit is idle.
// sequence, accept to result valid:
//   set pose and load landmark go straight to the result, move runs
//   CORDIC_STEPS cordic stages (one per cycle) and six shared multiplier
//   beats, sense runs six square beats and 33 square root steps.
//   one command is in flight at a time; the next beat is taken once the
//   result has moved into the output register.
// reset: pose and deviations clear to zero, the landmark store holds
//   nothing valid until loaded.
// stall: a held result waits in the output register; a finished command
//   then waits until that register is free.
module robot_pose_motion_and_range_sense_unit
    import rpms_pkg::*;
#(
    parameter int LANDMARK_COUNT = 16,
    parameter int CORDIC_STEPS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [15:0] turn_step,
    input  logic signed [31:0] forward_step,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [15:0]        coord_angle,
    input  logic [3:0]         landmark_index,
    input  logic               add_noise,
    input  logic signed [15:0] noise_first,
    input  logic signed [15:0] noise_second,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic [15:0]        pose_heading,
    output logic signed [31:0] range_value,
    output logic               range_valid
);

    rpms_cmd_t  cmd;
    rpms_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer
    rpms_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    rpms_dp #(
        .LANDMARK_COUNT (LANDMARK_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .turn_step      (turn_step),
        .forward_step   (forward_step),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_angle    (coord_angle),
        .landmark_index (landmark_index),
        .add_noise      (add_noise),
        .noise_first    (noise_first),
        .noise_second   (noise_second),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .pose_x         (pose_x),
        .pose_y         (pose_y),
        .pose_heading   (pose_heading),
        .range_value    (range_value),
        .range_valid    (range_valid)
    );

endmodule

[design/rpms_ctrl.sv]
// sequencing state machine of the robot pose, motion and range unit
module rpms_ctrl
    import rpms_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    output logic       in_ready,
    input  rpms_stat_t stat,
    output rpms_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DISP = 5'd1;
    localparam logic [4:0] S_SET  = 5'd2;
    localparam logic [4:0] S_LOAD = 5'd3;
    localparam logic [4:0] S_MN1  = 5'd4;
    localparam logic [4:0] S_MN2  = 5'd5;
    localparam logic [4:0] S_MN3  = 5'd6;
    localparam logic [4:0] S_MCI  = 5'd7;
    localparam logic [4:0] S_MCS  = 5'd8;
    localparam logic [4:0] S_MCF  = 5'd9;
    localparam logic [4:0] S_P0   = 5'd10;
    localparam logic [4:0] S_P1   = 5'd11;
    localparam logic [4:0] S_P2   = 5'd12;
    localparam logic [4:0] S_P3   = 5'd13;
    localparam logic [4:0] S_P4   = 5'd14;
    localparam logic [4:0] S_P5   = 5'd15;
    localparam logic [4:0] S_SR   = 5'd16;
    localparam logic [4:0] S_SD   = 5'd17;
    localparam logic [4:0] S_Q0   = 5'd18;
    localparam logic [4:0] S_Q1   = 5'd19;
    localparam logic [4:0] S_Q2   = 5'd20;
    localparam logic [4:0] S_Q3   = 5'd21;
    localparam logic [4:0] S_Q4   = 5'd22;
    localparam logic [4:0] S_Q5   = 5'd23;
    localparam logic [4:0] S_Q6   = 5'd24;
    localparam logic [4:0] S_SQI  = 5'd25;
    localparam logic [4:0] S_SQS  = 5'd26;
    localparam logic [4:0] S_RF   = 5'd27;
    localparam logic [4:0] S_DONE = 5'd28;

    localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);
    localparam logic [5:0] SQRT_LAST   = 6'(SQRT_STEPS - 1);

    logic [4:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.iter   = cnt_reg[4:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    CMD_MOVE:  state_next = S_MN1;
                    CMD_SET:   state_next = S_SET;
                    CMD_SENSE: state_next = stat.idx_ok ? S_SR : S_DONE;
                    CMD_LOAD:  state_next = S_LOAD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_SET:
            begin
                cmd.set_pose = 1'b1;
                state_next   = S_DONE;
            end
            S_LOAD:
            begin
                cmd.lm_write = stat.idx_ok;
                state_next   = S_DONE;
            end
            S_MN1:
            begin
                cmd.mul_sel = MUL_N1_TURN;
                state_next  = S_MN2;
            end
            S_MN2:
            begin
                cmd.nz1_cap = 1'b1;
                cmd.mul_sel = MUL_N2_FWD;
                state_next  = S_MN3;
            end
            S_MN3:
            begin
                cmd.nz2_cap  = 1'b1;
                cmd.head_upd = 1'b1;
                state_next   = S_MCI;
            end
            S_MCI:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = 6'd0;
                state_next      = S_MCS;
            end
            S_MCS:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == CORDIC_LAST)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_MCF;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_MCF:
            begin
                cmd.cordic_fin = 1'b1;
                state_next     = S_P0;
            end
            S_P0:
            begin
                cmd.mul_sel = MUL_DLO_C;
                state_next  = S_P1;
            end
            S_P1:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.acc_sh  = SH_0;
                cmd.mul_sel = MUL_DHI_C;
                state_next  = S_P2;
            end
            S_P2:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_17;
                cmd.mul_sel = MUL_DLO_S;
                state_next  = S_P3;
            end
            S_P3:
            begin
                cmd.pos_x_upd = 1'b1;
                cmd.acc_op    = ACC_LOAD;
                cmd.acc_sh    = SH_0;
                cmd.mul_sel   = MUL_DHI_S;
                state_next    = S_P4;
            end
            S_P4:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_17;
                state_next = S_P5;
            end
            S_P5:
            begin
                cmd.pos_y_upd = 1'b1;
                state_next    = S_DONE;
            end
            S_SR:
            begin
                cmd.lm_read = 1'b1;
                cmd.mul_sel = MUL_N1_SENSE;
                state_next  = S_SD;
            end
            S_SD:
            begin
                cmd.nz1_cap  = 1'b1;
                cmd.abs_calc = 1'b1;
                state_next   = S_Q0;
            end
            S_Q0:
            begin
                cmd.mul_sel = MUL_XL_XL;
                state_next  = S_Q1;
            end
            S_Q1:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.acc_sh  = SH_0;
                cmd.mul_sel = MUL_XH_XL;
                state_next  = S_Q2;
            end
            S_Q2:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_18;
                cmd.mul_sel = MUL_XH_XH;
                state_next  = S_Q3;
            end
            S_Q3:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_34;
                cmd.mul_sel = MUL_YL_YL;
                state_next  = S_Q4;
            end
            S_Q4:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_0;
                cmd.mul_sel = MUL_YH_YL;
                state_next  = S_Q5;
            end
            S_Q5:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_18;
                cmd.mul_sel = MUL_YH_YH;
                state_next  = S_Q6;
            end
            S_Q6:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_34;
                state_next = S_SQI;
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = 6'd0;
                state_next    = S_SQS;
            end
            S_SQS:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_RF;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_RF:
            begin
                cmd.range_upd = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // an accepted beat always leaves the idle state
    a_latch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (state_reg == S_DISP))
        else $error("accepted beat did not start processing");

    // the cordic counter never runs past the last stage
    a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MCS) |-> (cnt_reg <= CORDIC_LAST))
        else $error("cordic step counter out of range");

    // the root finishes after exactly its last step
    a_sqrt_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQS && cnt_reg == SQRT_LAST) |=> (state_reg == S_RF))
        else $error("square root did not finish on its last step");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!stat.out_full || out_ready))
        else $error("result register overwritten while full");
`endif

endmodule

[design/rpms_dp.sv]
// datapath: pose, landmark store, shared multiplier, cordic and square root
module rpms_dp
    import rpms_pkg::*;
#(
    parameter int LANDMARK_COUNT = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rpms_cmd_t          cmd,
    output rpms_stat_t         stat,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic [1:0]         command,
    input  logic signed [15:0] turn_step,
    input  logic signed [31:0] forward_step,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [15:0]        coord_angle,
    input  logic [3:0]         landmark_index,
    input  logic               add_noise,
    input  logic signed [15:0] noise_first,
    input  logic signed [15:0] noise_second,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic [15:0]        pose_heading,
    output logic signed [31:0] range_value,
    output logic               range_valid
);

    localparam int AW = (LANDMARK_COUNT > 1) ? $clog2(LANDMARK_COUNT) : 1;

    // configuration
    logic [23:0] fwd_dev_reg;
    logic [15:0] turn_dev_reg;
    logic [23:0] sense_dev_reg;

    // latched beat
    logic [1:0]         op_reg;
    logic signed [15:0] turn_reg;
    logic signed [31:0] fwd_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic [15:0]        cang_reg;
    logic [3:0]         idx_reg;
    logic               noisy_reg;
    logic signed [15:0] n1_reg;
    logic signed [15:0] n2_reg;

    // pose
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic [15:0]        heading_reg;

    // working registers
    logic signed [51:0] prod_reg;
    logic signed [67:0] acc_reg;
    logic signed [29:0] nz1_reg;
    logic signed [29:0] nz2_reg;
    logic signed [33:0] dist_reg;
    logic signed [33:0] cx_cor_reg;
    logic signed [33:0] cy_cor_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic [63:0]        lm_rd_reg;
    logic [32:0]        ax_reg;
    logic [32:0]        ay_reg;
    logic [65:0]        rad_reg;
    logic [35:0]        rem_reg;
    logic [32:0]        root_reg;
    logic signed [31:0] range_reg;
    logic               rvalid_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic [15:0]        out_h_reg;
    logic signed [31:0] out_r_reg;
    logic               out_rv_reg;

    logic [63:0] lm_mem [LANDMARK_COUNT];

    logic [8:0]          idx_wide;
    logic [AW-1:0]       addr;
    logic                idx_ok;
    logic signed [17:0]  mul_a;
    logic signed [33:0]  mul_b;
    logic signed [51:0]  prod_next;
    logic signed [67:0]  prod_wide;
    logic signed [67:0]  prod_al;
    logic signed [39:0]  sum_x;
    logic signed [39:0]  sum_y;
    logic signed [32:0]  dx;
    logic signed [32:0]  dy;
    logic signed [33:0]  xs;
    logic signed [33:0]  ys;
    logic signed [33:0]  atan_v;
    logic [31:0]         cor_u;
    logic [35:0]         rem_sh;
    logic [35:0]         trial;
    logic signed [39:0]  range_sum;

    assign idx_wide = {5'd0, idx_reg};
    assign addr     = idx_wide[AW-1:0];
    assign idx_ok   = (idx_wide < 9'(LANDMARK_COUNT));

    assign stat.op       = op_reg;
    assign stat.idx_ok   = idx_ok;
    assign stat.out_full = out_valid_reg;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_dev_reg   <= 24'd0;
            turn_dev_reg  <= 16'd0;
            sense_dev_reg <= 24'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FWD_DEV:   fwd_dev_reg   <= cfg_data;
                CFG_TURN_DEV:  turn_dev_reg  <= cfg_data[15:0];
                CFG_SENSE_DEV: sense_dev_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= command;
            turn_reg  <= turn_step;
            fwd_reg   <= forward_step;
            cx_reg    <= coord_x;
            cy_reg    <= coord_y;
            cang_reg  <= coord_angle;
            idx_reg   <= landmark_index;
            noisy_reg <= add_noise;
            n1_reg    <= noise_first;
            n2_reg    <= noise_second;
        end
    end

    // landmark store
    always_ff @(posedge clk)
    begin
        if (cmd.lm_write)
            lm_mem[addr] <= {cy_reg, cx_reg};
        if (cmd.lm_read)
            lm_rd_reg <= lm_mem[addr];
    end

    // multiplier operand selection
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_N1_TURN:
            begin
                mul_a = 18'(n1_reg);
                mul_b = $signed({18'd0, turn_dev_reg});
            end
            MUL_N1_SENSE:
            begin
                mul_a = 18'(n1_reg);
                mul_b = $signed({10'd0, sense_dev_reg});
            end
            MUL_N2_FWD:
            begin
                mul_a = 18'(n2_reg);
                mul_b = $signed({10'd0, fwd_dev_reg});
            end
            MUL_DLO_C:
            begin
                mul_a = $signed({1'b0, dist_reg[16:0]});
                mul_b = cx_cor_reg;
            end
            MUL_DHI_C:
            begin
                mul_a = 18'($signed(dist_reg[33:17]));
                mul_b = cx_cor_reg;
            end
            MUL_DLO_S:
            begin
                mul_a = $signed({1'b0, dist_reg[16:0]});
                mul_b = cy_cor_reg;
            end
            MUL_DHI_S:
            begin
                mul_a = 18'($signed(dist_reg[33:17]));
                mul_b = cy_cor_reg;
            end
            MUL_XL_XL:
            begin
                mul_a = $signed({1'b0, ax_reg[16:0]});
                mul_b = $signed({17'd0, ax_reg[16:0]});
            end
            MUL_XH_XL:
            begin
                mul_a = $signed({2'b0, ax_reg[32:17]});
                mul_b = $signed({17'd0, ax_reg[16:0]});
            end
            MUL_XH_XH:
            begin
                mul_a = $signed({2'b0, ax_reg[32:17]});
                mul_b = $signed({18'd0, ax_reg[32:17]});
            end
            MUL_YL_YL:
            begin
                mul_a = $signed({1'b0, ay_reg[16:0]});
                mul_b = $signed({17'd0, ay_reg[16:0]});
            end
            MUL_YH_YL:
            begin
                mul_a = $signed({2'b0, ay_reg[32:17]});
                mul_b = $signed({17'd0, ay_reg[16:0]});
            end
            MUL_YH_YH:
            begin
                mul_a = $signed({2'b0, ay_reg[32:17]});
                mul_b = $signed({18'd0, ay_reg[32:17]});
            end
            default:
            begin
                mul_a = 18'sd0;
                mul_b = 34'sd0;
            end
        endcase
    end

    assign prod_next = 52'(mul_a) * 52'(mul_b);
    assign prod_wide = 68'(prod_reg);

    // product alignment into the accumulator
    always_comb
    begin
        case (cmd.acc_sh)
            SH_0:    prod_al = prod_wide;
            SH_17:   prod_al = prod_wide <<< 17;
            SH_18:   prod_al = prod_wide <<< 18;
            SH_34:   prod_al = prod_wide <<< 34;
            default: prod_al = prod_wide;
        endcase
    end

    // multiplier, accumulator and scaled noise
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_al;
            ACC_ADD:  acc_reg <= acc_reg + prod_al;
            default:  ;
        endcase
        if (cmd.nz1_cap)
            nz1_reg <= $signed(prod_reg[41:12]);
        if (cmd.nz2_cap)
            nz2_reg <= $signed(prod_reg[41:12]);
    end

    // cordic rotation, one stage per cycle
    assign xs     = cx_cor_reg >>> cmd.iter;
    assign ys     = cy_cor_reg >>> cmd.iter;
    assign atan_v = $signed({2'b0, rpms_atan(cmd.iter)});
    assign cor_u  = {heading_reg, 16'd0};

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            flip_reg   <= heading_reg[15] ^ heading_reg[14];
            z_reg      <= 34'($signed({cor_u[31] ^ heading_reg[15] ^ heading_reg[14],
                                       cor_u[30:0]}));
            cx_cor_reg <= CORDIC_GAIN;
            cy_cor_reg <= 34'sd0;
            dist_reg   <= 34'(fwd_reg) + 34'(nz2_reg);
        end
        else if (cmd.cordic_step)
        begin
            if (!z_reg[33])
            begin
                cx_cor_reg <= cx_cor_reg - ys;
                cy_cor_reg <= cy_cor_reg + xs;
                z_reg      <= z_reg - atan_v;
            end
            else
            begin
                cx_cor_reg <= cx_cor_reg + ys;
                cy_cor_reg <= cy_cor_reg - xs;
                z_reg      <= z_reg + atan_v;
            end
        end
        else if (cmd.cordic_fin && flip_reg)
        begin
            cx_cor_reg <= -cx_cor_reg;
            cy_cor_reg <= -cy_cor_reg;
        end
    end

    // offset to the landmark and its magnitude
    assign dx = 33'($signed(lm_rd_reg[31:0])) - 33'(pos_x_reg);
    assign dy = 33'($signed(lm_rd_reg[63:32])) - 33'(pos_y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.abs_calc)
        begin
            ax_reg <= dx[32] ? 33'(-dx) : 33'(dx);
            ay_reg <= dy[32] ? 33'(-dy) : 33'(dy);
        end
    end

    // restoring square root, two radicand bits per step
    assign rem_sh = {rem_reg[33:0], rad_reg[65:64]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rad_reg  <= acc_reg[65:0];
            rem_reg  <= 36'd0;
            root_reg <= 33'd0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[63:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[31:0], 1'b0};
            end
        end
    end

    // pose updates
    assign sum_x = 40'(pos_x_reg) + 40'($signed(acc_reg[67:30]));
    assign sum_y = 40'(pos_y_reg) + 40'($signed(acc_reg[67:30]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= 32'sd0;
            pos_y_reg   <= 32'sd0;
            heading_reg <= 16'd0;
        end
        else
        begin
            if (cmd.set_pose)
            begin
                pos_x_reg   <= cx_reg;
                pos_y_reg   <= cy_reg;
                heading_reg <= cang_reg;
            end
            if (cmd.head_upd)
                heading_reg <= heading_reg + turn_reg[15:0] + nz1_reg[15:0];
            if (cmd.pos_x_upd)
                pos_x_reg <= rpms_sat32(sum_x);
            if (cmd.pos_y_upd)
                pos_y_reg <= rpms_sat32(sum_y);
        end
    end

    // sensed range with optional noise
    assign range_sum = 40'($signed({1'b0, root_reg}))
                     + (noisy_reg ? 40'(nz1_reg) : 40'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg  <= 32'sd0;
            rvalid_reg <= 1'b0;
        end
        else if (cmd.latch)
        begin
            range_reg  <= 32'sd0;
            rvalid_reg <= 1'b0;
        end
        else if (cmd.range_upd)
        begin
            range_reg  <= rpms_sat32(range_sum);
            rvalid_reg <= 1'b1;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x_reg  <= pos_x_reg;
            out_y_reg  <= pos_y_reg;
            out_h_reg  <= heading_reg;
            out_r_reg  <= range_reg;
            out_rv_reg <= rvalid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pose_x       = out_x_reg;
    assign pose_y       = out_y_reg;
    assign pose_heading = out_h_reg;
    assign range_value  = out_r_reg;
    assign range_valid  = out_rv_reg;

endmodule
